// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VGRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define VGRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/vgrt_pkg.sv -----
// Shared types and fixed widths for the voxel grid ray traversal core
package vgrt_pkg;

  localparam int CoordW = 16;
  localparam int OrgW   = 32;
  localparam int DirW   = 16;
  localparam int MagW   = 16;
  localparam int BndW   = 17;
  localparam int DistW  = 32;
  localparam int CellW  = 5;
  localparam int LenW   = 24;
  localparam int SqW    = 49;
  localparam int NumW   = 40;
  localparam int DenW   = 25;
  localparam int TnW    = 34;
  localparam int DivIters = 40;
  localparam int SqIters  = 25;
  localparam logic [CoordW-1:0] UnitQ14 = 16'd16384;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_t;

  // one classified input beat
  typedef struct packed {
    cmd_t                         cmd;
    logic [CellW-1:0]             cell_x;
    logic [CellW-1:0]             cell_y;
    logic [CellW-1:0]             cell_z;
    logic                         solid;
    logic [2:0][CoordW-1:0]       org_cell;
    logic [2:0][MagW-1:0]         mag;
    logic [2:0]                   neg;
    logic [2:0]                   act;
    logic [2:0][BndW-1:0]         bnd;
    logic [DistW-1:0]             reach;
  } vgrt_item_t;

  typedef struct packed {
    logic       valid;
    vgrt_item_t item;
  } vgrt_q_t;

endpackage

// ----- rtl/vgrt_div_lane.sv -----
// Restoring shift-subtract divider lane, one quotient bit per cycle while run is high
module vgrt_div_lane import vgrt_pkg::*; (
  input  logic            clk,
  input  logic            load,
  input  logic            run,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] quot
);

  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [DenW-1:0] rem_r;
  logic [DenW:0]   sh;
  logic [DenW:0]   diff;
  logic            ge;

  always_comb begin
    sh   = {rem_r, num_r[NumW-1]};
    ge   = sh >= {1'b0, den_r};
    diff = sh - {1'b0, den_r};
  end

  // quotient bits shift into the numerator register as it empties
  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run) begin
      rem_r <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
      num_r <= {num_r[NumW-2:0], ge};
    end
  end

  assign quot = num_r;

endmodule

// ----- rtl/vgrt_front.sv -----
// Front end: accepts beats, classifies them and queues them for the back end
`include "assert_macros.svh"
module vgrt_front import vgrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     clearing,
  input  logic                     in_command,
  input  logic [CellW-1:0]         in_cell_x,
  input  logic [CellW-1:0]         in_cell_y,
  input  logic [CellW-1:0]         in_cell_z,
  input  logic                     in_solid,
  input  logic signed [OrgW-1:0]   in_origin_x,
  input  logic signed [OrgW-1:0]   in_origin_y,
  input  logic signed [OrgW-1:0]   in_origin_z,
  input  logic signed [DirW-1:0]   in_dir_x,
  input  logic signed [DirW-1:0]   in_dir_y,
  input  logic signed [DirW-1:0]   in_dir_z,
  input  logic [DistW-1:0]         in_max_dist,
  input  logic                     pop,
  output logic                     busy,
  output vgrt_q_t                  head
);

  vgrt_item_t            q_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            cnt_r;
  logic                  push;
  vgrt_item_t            item;
  logic [2:0][DirW-1:0]  dirs;
  logic [2:0][OrgW-1:0]  orgs;

  assign dirs = {in_dir_z, in_dir_y, in_dir_x};
  assign orgs = {in_origin_z, in_origin_y, in_origin_x};

  assign busy = clearing || (cnt_r == 2'd2);
  assign push = start && !busy;

  // sign, magnitude and distance to the next boundary per axis
  always_comb begin
    item          = '0;
    item.cmd      = cmd_t'(in_command);
    item.cell_x   = in_cell_x;
    item.cell_y   = in_cell_y;
    item.cell_z   = in_cell_z;
    item.solid    = in_solid;
    item.reach    = in_max_dist;
    for (int i = 0; i < 3; i++) begin
      item.neg[i]  = dirs[i][DirW-1];
      item.act[i]  = |dirs[i];
      item.mag[i]  = dirs[i][DirW-1] ? (~dirs[i] + 16'd1) : dirs[i];
      item.bnd[i]  = dirs[i][DirW-1] ? {1'b0, orgs[i][15:0]}
                                     : (17'h10000 - {1'b0, orgs[i][15:0]});
      item.org_cell[i] = orgs[i][OrgW-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= item;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  `VGRT_ASSERT_IMP(a_pop_nonempty, pop, cnt_r != 2'd0)
  `VGRT_ASSERT_NXT(a_fill_count, push && !pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

// ----- rtl/vgrt_back.sv -----
// Back end: occupancy store, ray setup arithmetic and the cell walk
`include "assert_macros.svh"
module vgrt_back import vgrt_pkg::*; #(
  parameter int GRID_BITS = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vgrt_q_t                  head,
  output logic                     pop,
  output logic                     clearing,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [CoordW-1:0] out_hit_x,
  output logic signed [CoordW-1:0] out_hit_y,
  output logic signed [CoordW-1:0] out_hit_z,
  output logic signed [CoordW-1:0] out_normal_x,
  output logic signed [CoordW-1:0] out_normal_y,
  output logic signed [CoordW-1:0] out_normal_z,
  output logic [DistW-1:0]         out_distance
);

  localparam int AddrW = 3 * GRID_BITS;
  localparam int Cells = 1 << AddrW;
  localparam logic signed [CoordW-1:0] Side = CoordW'(1 << GRID_BITS);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_LEN  = 10'b00_0000_0010,
    S_SQRT = 10'b00_0000_0100,
    S_DIV  = 10'b00_0000_1000,
    S_TN   = 10'b00_0001_0000,
    S_RD0  = 10'b00_0010_0000,
    S_CHK0 = 10'b00_0100_0000,
    S_UNIT = 10'b00_1000_0000,
    S_STEP = 10'b01_0000_0000,
    S_CHK  = 10'b10_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  vgrt_item_t              it_r;
  logic [31:0]             acc_r;
  logic [32:0]             prod_r;
  logic [SqW-1:0]          sq_v_r, sq_res_r, sq_bit_r;
  logic [LenW-1:0]         len8_r;
  logic [2:0][TnW-1:0]     tn_r;
  logic [32:0]             lo_r;
  logic [2:0][CoordW-1:0]  c_r;
  logic [DistW-1:0]        t_r;
  logic [1:0]              axis_r;
  logic                    occ_q_r, ing_r;
  logic                    clearing_r;
  logic [AddrW-1:0]        clr_addr_r;
  logic                    out_valid_r;

  logic                    occ_mem [Cells];
  logic                    mem_we, mem_wdata;
  logic [AddrW-1:0]        mem_waddr, mem_raddr;

  // shared multiplier and divider lanes
  logic [1:0]              ax_sel;
  logic [16:0]             mul_a;
  logic [15:0]             mul_b;
  logic [32:0]             mul_p;
  logic                    lane_load, lane_run;
  logic [2:0][NumW-1:0]    lane_num, q;
  logic [2:0][DenW-1:0]    lane_den;

  // walk signals
  logic [31:0]             len2;
  logic [SqW-1:0]          sq_trial, sq_res_n;
  logic [5:0]              prev;
  logic [48:0]             tn_sum;
  logic [2:0]              ex;
  logic                    e01, e02, e12;
  logic [1:0]              ax;
  logic [TnW-1:0]          t_sel;
  logic [2:0][CoordW-1:0]  c_step, rd_c;
  logic                    rd_in;
  logic                    solid_q;

  assign clearing  = clearing_r;
  assign out_valid = out_valid_r;
  assign pop       = (state_r == S_IDLE) && head.valid && !clearing_r;
  assign solid_q   = occ_q_r && ing_r;

  // ---------------- multiplier ----------------
  always_comb begin
    ax_sel = 2'd0;
    mul_a  = '0;
    mul_b  = '0;
    if (state_r == S_LEN) begin
      ax_sel = (cnt_r < 6'd3) ? cnt_r[1:0] : 2'd0;
      mul_a  = {1'b0, it_r.mag[ax_sel]};
      mul_b  = it_r.mag[ax_sel];
    end else if (state_r == S_TN) begin
      ax_sel = (cnt_r < 6'd6) ? cnt_r[2:1] : 2'd0;
      mul_a  = it_r.bnd[ax_sel];
      mul_b  = cnt_r[0] ? q[ax_sel][31:16] : q[ax_sel][15:0];
    end
  end
  assign mul_p = mul_a * mul_b;

  // ---------------- divider lanes ----------------
  assign lane_load = ((state_r == S_DIV) || (state_r == S_UNIT)) && (cnt_r == 6'd0);
  assign lane_run  = ((state_r == S_DIV) || (state_r == S_UNIT)) && (cnt_r != 6'd0)
                     && (cnt_r <= 6'(DivIters));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_r == S_DIV) begin
        lane_num[i] = NumW'({len8_r, 8'b0});
        lane_den[i] = DenW'(it_r.mag[i]);
      end else begin
        lane_num[i] = (NumW'(it_r.mag[i]) << 23) + NumW'(len8_r);
        lane_den[i] = {len8_r, 1'b0};
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vgrt_div_lane u_lane (
      .clk  (clk),
      .load (lane_load),
      .run  (lane_run),
      .num  (lane_num[g]),
      .den  (lane_den[g]),
      .quot (q[g])
    );
  end

  // ---------------- setup arithmetic ----------------
  always_comb begin
    len2     = acc_r + prod_r[31:0];
    sq_trial = sq_res_r + sq_bit_r;
    sq_res_n = (sq_v_r >= sq_trial) ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
    prev     = cnt_r - 6'd1;
    tn_sum   = {16'b0, lo_r} + {prod_r, 16'b0};
  end

  // ---------------- axis choice for the walk ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = ($signed(c_r[i]) < 0 && (it_r.neg[i] || !it_r.act[i]))
              || ($signed(c_r[i]) >= Side && !it_r.neg[i]);
    end
    e01 = it_r.act[0] && (!it_r.act[1] || tn_r[0] < tn_r[1]);
    e02 = it_r.act[0] && (!it_r.act[2] || tn_r[0] < tn_r[2]);
    e12 = it_r.act[1] && (!it_r.act[2] || tn_r[1] < tn_r[2]);
    priority if (e01 && e02) ax = 2'd0;
    else if (e12)            ax = 2'd1;
    else                     ax = 2'd2;
    t_sel     = tn_r[ax];
    c_step    = c_r;
    c_step[ax] = it_r.neg[ax] ? (c_r[ax] - 16'd1) : (c_r[ax] + 16'd1);
    rd_c      = (state_r == S_STEP) ? c_step : c_r;
    rd_in     = 1'b1;
    for (int i = 0; i < 3; i++) begin
      rd_in = rd_in && !rd_c[i][CoordW-1] && ($signed(rd_c[i]) < Side);
    end
  end

  // ---------------- occupancy store ----------------
  always_comb begin
    mem_raddr = {rd_c[0][GRID_BITS-1:0], rd_c[1][GRID_BITS-1:0], rd_c[2][GRID_BITS-1:0]};
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = 1'b0;
    if (clearing_r) begin
      mem_we = 1'b1;
    end else if (pop && head.item.cmd == CMD_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = {GRID_BITS'(head.item.cell_x), GRID_BITS'(head.item.cell_y),
                   GRID_BITS'(head.item.cell_z)};
      mem_wdata = head.item.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    occ_q_r <= occ_mem[mem_raddr];
    ing_r   <= rd_in;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (pop && head.item.cmd == CMD_CAST) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (cnt_r == 6'd3) begin
          cnt_nxt   = '0;
          state_nxt = (len2 == 32'd0) ? S_IDLE : S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 6'(SqIters - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == 6'(DivIters)) begin
          cnt_nxt   = '0;
          state_nxt = S_TN;
        end
      end
      S_TN: begin
        if (cnt_r == 6'd6) begin
          cnt_nxt   = '0;
          state_nxt = S_RD0;
        end
      end
      S_RD0:  state_nxt = S_CHK0;
      S_CHK0: begin
        cnt_nxt   = '0;
        state_nxt = solid_q ? S_UNIT : S_STEP;
      end
      S_UNIT: begin
        if (cnt_r == 6'(DivIters + 1)) state_nxt = S_IDLE;
      end
      S_STEP: begin
        if ((|ex) || (t_sel > {2'b0, it_r.reach})) state_nxt = S_IDLE;
        else                                       state_nxt = S_CHK;
      end
      S_CHK:   state_nxt = solid_q ? S_IDLE : S_STEP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b0;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) clearing_r <= 1'b0;
      end
      if ((state_r == S_LEN && cnt_r == 6'd3 && len2 == 32'd0)
          || (state_r == S_UNIT && cnt_r == 6'(DivIters + 1))
          || (state_r == S_STEP && state_nxt == S_IDLE)
          || (state_r == S_CHK && solid_q)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        it_r  <= head.item;
        c_r   <= head.item.org_cell;
        acc_r <= '0;
      end
      S_LEN: begin
        if (cnt_r < 6'd3)  prod_r <= mul_p;
        if (cnt_r != 6'd0) acc_r  <= len2;
        if (cnt_r == 6'd3) begin
          sq_v_r   <= {1'b0, len2, 16'b0};
          sq_res_r <= '0;
          sq_bit_r <= SqW'(1) << (SqW - 1);
          out_hit      <= 1'b0;
          out_hit_x    <= '0;
          out_hit_y    <= '0;
          out_hit_z    <= '0;
          out_normal_x <= '0;
          out_normal_y <= '0;
          out_normal_z <= '0;
          out_distance <= '0;
        end
      end
      S_SQRT: begin
        if (sq_v_r >= sq_trial) sq_v_r <= sq_v_r - sq_trial;
        sq_res_r <= sq_res_n;
        sq_bit_r <= sq_bit_r >> 2;
        if (cnt_r == 6'(SqIters - 1)) len8_r <= sq_res_n[LenW-1:0];
      end
      S_DIV: ;
      S_TN: begin
        if (cnt_r < 6'd6) prod_r <= mul_p;
        if (cnt_r != 6'd0) begin
          if (!prev[0]) lo_r <= prod_r;
          else          tn_r[prev[2:1]] <= {1'b0, tn_sum[48:16]};
        end
      end
      S_RD0, S_CHK0: ;
      S_UNIT: begin
        if (cnt_r == 6'(DivIters + 1)) begin
          out_hit      <= 1'b1;
          out_hit_x    <= c_r[0];
          out_hit_y    <= c_r[1];
          out_hit_z    <= c_r[2];
          out_normal_x <= it_r.neg[0] ? q[0][15:0] : -q[0][15:0];
          out_normal_y <= it_r.neg[1] ? q[1][15:0] : -q[1][15:0];
          out_normal_z <= it_r.neg[2] ? q[2][15:0] : -q[2][15:0];
          out_distance <= '0;
        end
      end
      S_STEP: begin
        c_r        <= c_step;
        tn_r[ax]   <= t_sel + TnW'(q[ax][31:0]);
        t_r        <= t_sel[DistW-1:0];
        axis_r     <= ax;
        out_hit      <= 1'b0;
        out_hit_x    <= '0;
        out_hit_y    <= '0;
        out_hit_z    <= '0;
        out_normal_x <= '0;
        out_normal_y <= '0;
        out_normal_z <= '0;
        out_distance <= '0;
      end
      S_CHK: begin
        if (solid_q) begin
          out_hit      <= 1'b1;
          out_hit_x    <= c_r[0];
          out_hit_y    <= c_r[1];
          out_hit_z    <= c_r[2];
          out_normal_x <= (axis_r == 2'd0) ? (it_r.neg[0] ? UnitQ14 : -UnitQ14) : '0;
          out_normal_y <= (axis_r == 2'd1) ? (it_r.neg[1] ? UnitQ14 : -UnitQ14) : '0;
          out_normal_z <= (axis_r == 2'd2) ? (it_r.neg[2] ? UnitQ14 : -UnitQ14) : '0;
          out_distance <= t_r;
        end
      end
      default: ;
    endcase
  end

  `VGRT_ASSERT_IMP(a_pop_when_idle, pop, state_r == S_IDLE && !clearing_r)
  `VGRT_ASSERT_IMP(a_result_ends_cast, out_valid_r, state_r == S_IDLE && !clearing_r)

endmodule

// ----- rtl/voxel_grid_ray_traversal_core.sv -----
// Top level of the voxel grid ray traversal core
// Voxel grid ray caster over a cubic occupancy grid of 2^GRID_BITS cells a
// side. A beat is taken when start is high and busy is low. A write beat
// (in_command low) sets one cell's solid bit and gives no result; a cast
// beat walks the ray from the origin's cell and gives exactly one result,
// shown on the out_ ports for a single cycle with out_valid high. There is
// no back-pressure on results: the receiver must take every strobe.
// After reset the grid is cleared one cell a cycle, all 2^(3*GRID_BITS)
// cells (32768 at the default), and busy stays high for all of that time.
// A cast runs through the back-end sequencer in order: the squared length
// on the one shared multiplier, the bit-pair square root, the three parallel
// per-axis crossing divisions, the first-crossing products, a read of the
// origin's cell, then for each cell stepped an address and a registered
// store read. A start inside a solid cell runs the unit direction division
// instead of the walk. A zero direction ends after the squared length. A
// write is stored in the back end as it is taken from the queue. A
// two-beat queue sits between front and back, so start can be taken
// while a cast is still being worked on.
module voxel_grid_ray_traversal_core import vgrt_pkg::*; #(
  parameter int GRID_BITS = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [CellW-1:0]         in_cell_x,
  input  logic [CellW-1:0]         in_cell_y,
  input  logic [CellW-1:0]         in_cell_z,
  input  logic                     in_solid,
  input  logic signed [OrgW-1:0]   in_origin_x,
  input  logic signed [OrgW-1:0]   in_origin_y,
  input  logic signed [OrgW-1:0]   in_origin_z,
  input  logic signed [DirW-1:0]   in_dir_x,
  input  logic signed [DirW-1:0]   in_dir_y,
  input  logic signed [DirW-1:0]   in_dir_z,
  input  logic [DistW-1:0]         in_max_dist,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [CoordW-1:0] out_hit_x,
  output logic signed [CoordW-1:0] out_hit_y,
  output logic signed [CoordW-1:0] out_hit_z,
  output logic signed [CoordW-1:0] out_normal_x,
  output logic signed [CoordW-1:0] out_normal_y,
  output logic signed [CoordW-1:0] out_normal_z,
  output logic [DistW-1:0]         out_distance
);

  vgrt_q_t head;
  logic    pop;
  logic    clearing;

  // front end: decode, per-axis sign/magnitude/boundary, two-beat queue
  vgrt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .clearing    (clearing),
    .in_command  (in_command),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_cell_z   (in_cell_z),
    .in_solid    (in_solid),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .in_max_dist (in_max_dist),
    .pop         (pop),
    .busy        (busy),
    .head        (head)
  );

  // back end: grid store, setup arithmetic, cell-by-cell walk
  vgrt_back #(
    .GRID_BITS (GRID_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_hit_x    (out_hit_x),
    .out_hit_y    (out_hit_y),
    .out_hit_z    (out_hit_z),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z),
    .out_distance (out_distance)
  );

endmodule

// ----- test/vgrt_ray_checker.sv -----
// Checker for the voxel grid ray traversal core: watches both channels, predicts, compares
module vgrt_ray_checker import vgrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_command,
  input  logic [CellW-1:0]         in_cell_x,
  input  logic [CellW-1:0]         in_cell_y,
  input  logic [CellW-1:0]         in_cell_z,
  input  logic                     in_solid,
  input  logic signed [OrgW-1:0]   in_origin_x,
  input  logic signed [OrgW-1:0]   in_origin_y,
  input  logic signed [OrgW-1:0]   in_origin_z,
  input  logic signed [DirW-1:0]   in_dir_x,
  input  logic signed [DirW-1:0]   in_dir_y,
  input  logic signed [DirW-1:0]   in_dir_z,
  input  logic [DistW-1:0]         in_max_dist,
  input  logic                     out_valid,
  input  logic                     out_hit,
  input  logic signed [CoordW-1:0] out_hit_x,
  input  logic signed [CoordW-1:0] out_hit_y,
  input  logic signed [CoordW-1:0] out_hit_z,
  input  logic signed [CoordW-1:0] out_normal_x,
  input  logic signed [CoordW-1:0] out_normal_y,
  input  logic signed [CoordW-1:0] out_normal_z,
  input  logic [DistW-1:0]         out_distance,
  output int                       errors,
  output int                       pending,
  output int                       hits_seen
);

  localparam int Side = 32;

  typedef struct {
    logic              hit;
    logic [15:0]       cx, cy, cz;
    logic [15:0]       nx, ny, nz;
    logic [DistW-1:0]  span;
  } ray_answer_t;

  bit          occ [0:Side*Side*Side-1];
  ray_answer_t answers_q [$];

  function automatic longint unsigned root48(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 48;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit solid_at(input int x, input int y, input int z);
    if (x < 0 || x >= Side || y < 0 || y >= Side || z < 0 || z >= Side) return 0;
    return occ[(x << 10) | (y << 5) | z];
  endfunction

  // axis i crosses strictly ahead of axis j; a still axis never crosses
  function automatic bit crosses_first(input bit ai, input bit aj,
                                       input longint unsigned ti,
                                       input longint unsigned tj);
    if (!ai) return 0;
    if (!aj) return 1;
    return ti < tj;
  endfunction

  function automatic ray_answer_t trace_ray(
      input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
      input logic signed [15:0] dx, input logic signed [15:0] dy,
      input logic signed [15:0] dz, input logic [31:0] maxd);
    ray_answer_t r;
    logic [31:0] org [3];
    int d [3];
    int c [3];
    int s [3];
    bit act [3];
    longint unsigned mag [3], dt [3], tn [3];
    longint unsigned len2, len8, bnd, frac, u, t;
    longint signed su;
    int a;
    r = '{hit: 0, cx: 0, cy: 0, cz: 0, nx: 0, ny: 0, nz: 0, span: 0};
    org[0] = ox; org[1] = oy; org[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      len2 += mag[i] * mag[i];
      s[i] = (d[i] > 0) ? 1 : ((d[i] < 0) ? -1 : 0);
      act[i] = (s[i] != 0);
    end
    if (len2 == 0) return r;
    len8 = root48(len2 << 16);
    for (int i = 0; i < 3; i++) begin
      frac = org[i][15:0];
      c[i] = int'($signed(org[i][31:16]));
      if (act[i]) begin
        bnd = (s[i] > 0) ? (65536 - frac) : frac;
        dt[i] = (len8 << 8) / mag[i];
        tn[i] = (bnd * dt[i]) >> 16;
      end else begin
        dt[i] = 0;
        tn[i] = 0;
      end
    end
    // start inside a solid cell: distance 0, normal against the direction
    if (solid_at(c[0], c[1], c[2])) begin
      r.hit = 1;
      r.cx = c[0][15:0]; r.cy = c[1][15:0]; r.cz = c[2][15:0];
      for (int i = 0; i < 3; i++) begin
        u = (mag[i] * (64'd2 << 22) + len8) / (2 * len8);
        su = (d[i] < 0) ? -longint'(u) : longint'(u);
        su = -su;
        if (i == 0) r.nx = su[15:0];
        else if (i == 1) r.ny = su[15:0];
        else r.nz = su[15:0];
      end
      return r;
    end
    forever begin
      for (int i = 0; i < 3; i++)
        if ((c[i] < 0 && s[i] <= 0) || (c[i] >= Side && s[i] >= 0)) return r;
      if (crosses_first(act[0], act[1], tn[0], tn[1]) &&
          crosses_first(act[0], act[2], tn[0], tn[2])) a = 0;
      else if (crosses_first(act[1], act[2], tn[1], tn[2])) a = 1;
      else a = 2;
      c[a] += s[a];
      t = tn[a];
      tn[a] += dt[a];
      if (t > maxd) return r;
      if (solid_at(c[0], c[1], c[2])) begin
        r.hit = 1;
        r.cx = c[0][15:0]; r.cy = c[1][15:0]; r.cz = c[2][15:0];
        if (a == 0) r.nx = (s[a] > 0) ? -16'sd16384 : 16'sd16384;
        else if (a == 1) r.ny = (s[a] > 0) ? -16'sd16384 : 16'sd16384;
        else r.nz = (s[a] > 0) ? -16'sd16384 : 16'sd16384;
        r.span = t[31:0];
        return r;
      end
    end
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    hits_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ray_answer_t e;
    if (!rst_n) begin
      for (int i = 0; i < Side*Side*Side; i++) occ[i] = 0;
    end else begin
      if (out_valid) begin
        if (answers_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, hit %b", $time, out_hit);
          errors++;
        end else begin
          e = answers_q.pop_front();
          if (out_hit) hits_seen++;
          if (out_hit !== e.hit) flag("hit", e.hit, out_hit);
          if (out_hit_x !== e.cx) flag("hit_x", e.cx, out_hit_x);
          if (out_hit_y !== e.cy) flag("hit_y", e.cy, out_hit_y);
          if (out_hit_z !== e.cz) flag("hit_z", e.cz, out_hit_z);
          if (out_normal_x !== e.nx) flag("normal_x", e.nx, out_normal_x);
          if (out_normal_y !== e.ny) flag("normal_y", e.ny, out_normal_y);
          if (out_normal_z !== e.nz) flag("normal_z", e.nz, out_normal_z);
          if (out_distance !== e.span) flag("distance", e.span, out_distance);
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE)
          occ[{in_cell_x, in_cell_y, in_cell_z}] = in_solid;
        else
          answers_q.push_back(trace_ray(in_origin_x, in_origin_y, in_origin_z,
                                        in_dir_x, in_dir_y, in_dir_z, in_max_dist));
      end
    end
    pending = answers_q.size();
  end

endmodule

// ----- test/voxel_grid_ray_traversal_core_tb.sv -----
// Testbench top for the voxel grid ray traversal core: stimulus and verdict
module voxel_grid_ray_traversal_core_tb;
  import vgrt_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_command;
  logic [CellW-1:0]         in_cell_x, in_cell_y, in_cell_z;
  logic                     in_solid;
  logic signed [OrgW-1:0]   in_origin_x, in_origin_y, in_origin_z;
  logic signed [DirW-1:0]   in_dir_x, in_dir_y, in_dir_z;
  logic [DistW-1:0]         in_max_dist;
  logic                     out_valid, out_hit;
  logic signed [CoordW-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic signed [CoordW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [DistW-1:0]         out_distance;
  int                       errors, pending, hits_seen;
  int                       n_writes, n_casts;

  voxel_grid_ray_traversal_core uut (.*);

  vgrt_ray_checker chk (.*);

  // free-running clock, 10 units a period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle gap after a beat: mostly none or short, now and then long
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(99);
    if (r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 80);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one beat on the command channel; returns once the core has taken it
  task automatic send_beat(input cmd_t cmd, input logic [4:0] cx, input logic [4:0] cy,
                           input logic [4:0] cz, input logic sol,
                           input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [15:0] dx,
                           input logic [15:0] dy, input logic [15:0] dz,
                           input logic [31:0] md);
    start       <= 1'b1;
    in_command  <= cmd;
    in_cell_x   <= cx;
    in_cell_y   <= cy;
    in_cell_z   <= cz;
    in_solid    <= sol;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_origin_z <= oz;
    in_dir_x    <= dx;
    in_dir_y    <= dy;
    in_dir_z    <= dz;
    in_max_dist <= md;
    do @(posedge clk); while (busy);
    if (cmd == CMD_WRITE) n_writes++;
    else n_casts++;
    idle_gap();
  endtask

  task automatic write_cell(input int x, input int y, input int z, input bit sol);
    send_beat(CMD_WRITE, x[4:0], y[4:0], z[4:0], sol, $urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic cast_ray(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [31:0] oz, input logic [15:0] dx,
                          input logic [15:0] dy, input logic [15:0] dz,
                          input logic [31:0] md);
    send_beat(CMD_CAST, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
              ox, oy, oz, dx, dy, dz, md);
  endtask

  // Q16.16 origin near the grid: cell index from -4 to 36 with a random fraction
  function automatic logic [31:0] near_coord();
    int cidx;
    cidx = int'($urandom_range(0, 40)) - 4;
    return {cidx[15:0], 16'($urandom)};
  endfunction

  function automatic logic [15:0] rand_dir_part(input int mode, input logic [15:0] tie);
    if (mode == 1 && $urandom_range(2) == 0) return 16'd0;
    if (mode == 2) return $urandom_range(1) ? tie : -tie;
    return 16'($urandom);
  endfunction

  initial begin
    int r, mode;
    logic [15:0] tie;
    logic [31:0] md;
    n_writes = 0;
    n_casts = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_WRITE;
    {in_cell_x, in_cell_y, in_cell_z, in_solid} = '0;
    {in_origin_x, in_origin_y, in_origin_z} = '0;
    {in_dir_x, in_dir_y, in_dir_z} = '0;
    in_max_dist = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero direction gives a miss
    cast_ray(32'h0002_8000, 32'h0002_8000, 32'h0002_8000, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    // single solid cell approached from both sides along x
    write_cell(10, 10, 10, 1);
    cast_ray(32'h0002_8000, 32'h000A_8000, 32'h000A_8000, 16'sd16384, 16'd0, 16'd0,
             32'h0040_0000);
    cast_ray(32'h0014_0000, 32'h000A_8000, 32'h000A_8000, -16'sd16384, 16'd0, 16'd0,
             32'h0040_0000);
    // start inside a solid cell
    cast_ray(32'h000A_8000, 32'h000A_8000, 32'h000A_8000, 16'sd5000, -16'sd9000, 16'sd12000,
             32'd0);
    // on a cell boundary stepping downward: crossing at distance 0
    cast_ray(32'h000B_0000, 32'h000A_8000, 32'h000A_8000, -16'sd300, 16'd0, 16'd0, 32'd0);
    // exact diagonal tie, later axis wins
    write_cell(11, 11, 10, 1);
    write_cell(10, 11, 10, 1);
    cast_ray(32'h0009_0000, 32'h0009_0000, 32'h000A_8000, 16'sd8000, 16'sd8000, 16'd0,
             32'h0010_0000);
    // too short to reach, then max reach
    cast_ray(32'h0002_8000, 32'h000A_8000, 32'h000A_8000, 16'sd16384, 16'd0, 16'd0, 32'd0);
    cast_ray(32'h0002_8000, 32'h000A_8000, 32'h000A_8000, 16'sd32767, 16'sd1, 16'd0,
             32'hFFFF_FFFF);
    // grid corners and direction extremes
    write_cell(31, 31, 31, 1);
    write_cell(0, 0, 0, 1);
    cast_ray(32'h0028_0000, 32'h0028_0000, 32'h0028_0000, -16'sd32768, -16'sd32768,
             -16'sd32768, 32'hFFFF_FFFF);
    cast_ray(32'hFFFC_0000, 32'hFFFC_0000, 32'hFFFC_0000, 16'sd32767, 16'sd32767,
             16'sd32767, 32'hFFFF_FFFF);
    // clearing a cell again
    write_cell(0, 0, 0, 0);
    cast_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'sd1, 16'sd1, 16'sd1, 32'h0001_0000);
    // origin extremes, heading away and toward
    cast_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'sd100, -16'sd100, 16'd0,
             32'hFFFF_FFFF);
    cast_ray(32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 16'sd16384, 16'd0, 16'd0,
             32'h0004_0000);
    cast_ray(32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000, 16'd0, -16'sd16384, 16'sd3,
             32'h0004_0000);

    // random: cluster writes build a dense block that the casts keep running into
    for (int k = 0; k < 1900; k++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        write_cell($urandom_range(8, 15), $urandom_range(8, 15), $urandom_range(8, 15),
                   $urandom_range(3) != 0);
      end else if (r < 40) begin
        write_cell($urandom_range(31), $urandom_range(31), $urandom_range(31),
                   1'($urandom_range(1)));
      end else begin
        mode = $urandom_range(2);
        tie = 16'($urandom_range(1, 32767));
        md = $urandom_range(3) ? $urandom_range(0, 32'h0032_0000) : $urandom;
        if (r < 90)
          cast_ray(near_coord(), near_coord(), near_coord(), rand_dir_part(mode, tie),
                   rand_dir_part(mode, tie), rand_dir_part(mode, tie), md);
        else
          // wild origin: kept short so a far ray is cut off quickly
          cast_ray($urandom, $urandom, $urandom, rand_dir_part(mode, tie),
                   rand_dir_part(mode, tie), rand_dir_part(mode, tie),
                   $urandom_range(0, 32'h0014_0000));
      end
    end
    start <= 1'b0;

    // drain, then allow for a write still in the back end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Run covered %0d cell writes and %0d casts, %0d casts hitting a solid cell.",
             n_writes, n_casts, hits_seen);
    if (errors == 0 && pending == 0) begin
      $display("voxel_grid_ray_traversal_core_tb: PASS");
    end else begin
      $display("voxel_grid_ray_traversal_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog: reset clear plus the slowest plausible walks, with wide margin
  initial begin
    #50_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("voxel_grid_ray_traversal_core_tb: FAIL");
    $finish;
  end

endmodule
